[src/joint_velocity_limit_projector_defines.svh]
// Assertion macros for the joint velocity limit projector.
// The macros expect signals named clk and rst in the scope where they are used.
`ifndef JOINT_VELOCITY_LIMIT_PROJECTOR_DEFINES_SVH
`define JOINT_VELOCITY_LIMIT_PROJECTOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define JVLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jvlp assertion failed");

// Next-cycle implication, disabled while in reset.
`define JVLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jvlp assertion failed");

`endif

[src/jvlp_pkg.sv]
`timescale 1ns / 1ps

package jvlp_pkg;

  // Joints with limit registers
  localparam int JOINT_COUNT = 5;
  localparam int LIMIT_REGS  = 5;

  localparam int CFG_IDX_W = 3;
  localparam int PIPE_DEPTH = 11;

  // Register indexes beyond the joint limit registers
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_ON   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_BAND = 3'd6;

  localparam logic [2:0] ELBOW_JOINT = 3'd2;

  // -pi, +pi, -1.0, +1.0 in Q3.12
  localparam logic [63:0] LIMITS_RESET = 64'h1000_F000_3244_CDBC;
  localparam logic [12:0] GUARD_BAND_RESET = 13'd410;

  localparam logic signed [16:0] STOP_MARGIN = 17'sd82;
  localparam logic signed [16:0] SOFT_MARGIN = 17'sd410;
  localparam logic signed [16:0] ELBOW_SPAN  = 17'sd819;
  localparam logic signed [15:0] ELBOW_PUSH  = -16'sd2048;

  // Soft slowdown divisor 107584 = 64 * 1681; the 64 is a shift.
  localparam int SOFT_PRE_SHIFT = 6;
  localparam int SOFT_SHIFT = 41;
  localparam logic [10:0] SOFT_DIV_ODD = 11'd1681;
  localparam logic [30:0] SOFT_RECIP = 31'((64'd1 << SOFT_SHIFT) / 64'd1681);

  // Elbow slowdown divisor 670761 = 819 * 819
  localparam int ELBOW_SHIFT = 36;
  localparam logic [19:0] ELBOW_DIV = 20'd670761;
  localparam logic [16:0] ELBOW_RECIP = 17'((64'd1 << ELBOW_SHIFT) / 64'd670761);

  typedef struct packed {
    logic signed [15:0] vmax;
    logic signed [15:0] vmin;
    logic signed [15:0] pmax;
    logic signed [15:0] pmin;
  } limits_t;

endpackage

[src/jvlp_limits.sv]
`timescale 1ns / 1ps

// Configuration register file and per-joint limit lookup.
module jvlp_limits (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jvlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic [2:0]                      sel,
  output jvlp_pkg::limits_t               lim,
  output logic                            guard_on,
  output logic [12:0]                     guard_band
);
  import jvlp_pkg::*;

  logic [63:0] joint_limits [LIMIT_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIMIT_REGS; i++) begin
        joint_limits[i] <= LIMITS_RESET;
      end
      guard_on   <= 1'b0;
      guard_band <= GUARD_BAND_RESET;
    end else if (cfg_valid) begin
      if (cfg_index < CFG_IDX_W'(LIMIT_REGS)) begin
        joint_limits[cfg_index] <= cfg_data;
      end else if (cfg_index == REG_GUARD_ON) begin
        guard_on <= cfg_data[0];
      end else if (cfg_index == REG_GUARD_BAND) begin
        guard_band <= cfg_data[12:0];
      end
    end
  end

  // out-of-range joints read zero; the pipeline zeroes their velocity anyway
  assign lim = (sel < 3'(LIMIT_REGS)) ? limits_t'(joint_limits[sel]) : '0;

endmodule

[src/joint_velocity_limit_projector.sv]
`timescale 1ns / 1ps

// Joint velocity limit projector.
// Input stream (s_axis_*): one transaction per request carrying the joint
// index, current position, desired velocity (Q3.12) and step time (Q0.16).
// Output stream (m_axis_*): exactly one transaction per request, in order,
// carrying the safe velocity (Q3.12) and a flag set when it differs from
// the desired velocity.
// Config channel (cfg_*): writes one register per transaction; index 0..4
// are joint limit words, 5 the elbow guard enable, 6 the guard band.
// cfg_ready is always high; write only while the pipeline is drained.
// Throughput: one transaction per cycle while the output is not stalled.
// The pipeline has 11 stages, the first loading on the accepting edge
// (two multiply-by-reciprocal divisions, each a product, a reciprocal
// product and a correction stage).
// Reset: synchronous; empties the pipeline and restores the default limits.
// Stall: each stage holds while the stage after it is full and stalled;
// bubbles close up, so input is still taken until every stage is full.
module joint_velocity_limit_projector (
  input  logic                           clk,
  input  logic                           rst,
  // fields from bit 0: joint_index[2:0], position[15:0],
  // desired_velocity[15:0], step_time[15:0], zero pad[4:0]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [55:0]                    s_axis_tdata,
  // fields from bit 0: safe_velocity[15:0], was_limited, zero pad[6:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jvlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);
  import jvlp_pkg::*;

  // Per-item fields carried down the first half of the pipe
  typedef struct packed {
    logic signed [15:0] pos;
    logic signed [15:0] want;
    logic [15:0]        dt;
    logic signed [15:0] pmin;
    logic signed [15:0] pmax;
    logic [12:0]        band;
    logic               elb;
  } carry_t;

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] en;

  // ---------------- handshake: a stage loads if empty or draining
  always_comb begin
    en[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || m_axis_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------- stage 0: limit lookup and velocity clamp
  logic [2:0]         in_idx;
  logic signed [15:0] in_pos;
  logic signed [15:0] in_want;
  logic [15:0]        in_dt;
  limits_t            lim;
  logic               guard_on;
  logic [12:0]        guard_band;
  logic               joint_ok;
  logic signed [15:0] vclamp;

  assign in_idx  = s_axis_tdata[2:0];
  assign in_pos  = $signed(s_axis_tdata[18:3]);
  assign in_want = $signed(s_axis_tdata[34:19]);
  assign in_dt   = s_axis_tdata[50:35];

  jvlp_limits u_limits (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sel        (in_idx),
    .lim        (lim),
    .guard_on   (guard_on),
    .guard_band (guard_band)
  );

  assign joint_ok = ({1'b0, in_idx} < 4'(JOINT_COUNT)) && ({1'b0, in_idx} < 4'(LIMIT_REGS));

  // min clamp last so it wins when the limits cross
  always_comb begin
    vclamp = in_want;
    if (in_want > lim.vmax) begin
      vclamp = lim.vmax;
    end
    if (vclamp < lim.vmin) begin
      vclamp = lim.vmin;
    end
    if (!joint_ok) begin
      vclamp = '0;
    end
  end

  carry_t             c0;
  logic signed [15:0] vc0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c0.pos  <= in_pos;
      c0.want <= in_want;
      c0.dt   <= in_dt;
      c0.pmin <= lim.pmin;
      c0.pmax <= lim.pmax;
      c0.band <= guard_band;
      c0.elb  <= (in_idx == ELBOW_JOINT) && guard_on;
      vc0     <= vclamp;
    end
  end

  // ---------------- stage 1: distance to the approached limit, e squared
  logic signed [16:0] dist1;
  logic signed [16:0] e1;
  logic [8:0]         e1_u;

  assign dist1 = (vc0 > 16'sd0) ?
                 ($signed({c0.pmax[15], c0.pmax}) - $signed({c0.pos[15], c0.pos})) :
                 ($signed({c0.pos[15], c0.pos}) - $signed({c0.pmin[15], c0.pmin}));
  assign e1   = dist1 - STOP_MARGIN;
  assign e1_u = e1[8:0];

  carry_t             c1;
  logic signed [15:0] vc1;
  logic               hard1;
  logic               slow1;
  logic [16:0]        esq1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c1    <= c0;
      vc1   <= vc0;
      hard1 <= dist1 < STOP_MARGIN;
      slow1 <= (dist1 >= STOP_MARGIN) && (dist1 < SOFT_MARGIN);
      esq1  <= 17'({9'd0, e1_u} * {9'd0, e1_u});
    end
  end

  // ---------------- stage 2: v * e^2, magnitude, /64
  logic signed [33:0] p2;
  logic [33:0]        mag2;

  always_comb begin
    p2   = $signed(vc1) * $signed({1'b0, esq1});
    mag2 = p2[33] ? $unsigned(-p2) : $unsigned(p2);
  end

  carry_t             c2;
  logic signed [15:0] vc2;
  logic               hard2;
  logic               slow2;
  logic               neg2;
  logic [25:0]        x2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c2    <= c1;
      vc2   <= vc1;
      hard2 <= hard1;
      slow2 <= slow1;
      neg2  <= vc1[15];
      x2    <= mag2[SOFT_PRE_SHIFT+25:SOFT_PRE_SHIFT];
    end
  end

  // ---------------- stage 3: quotient estimate by reciprocal (/1681)
  logic [56:0] pr3;

  assign pr3 = {31'd0, x2} * {26'd0, SOFT_RECIP};

  carry_t             c3;
  logic signed [15:0] vc3;
  logic               hard3;
  logic               slow3;
  logic               neg3;
  logic [25:0]        x3;
  logic [15:0]        q03;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      c3    <= c2;
      vc3   <= vc2;
      hard3 <= hard2;
      slow3 <= slow2;
      neg3  <= neg2;
      x3    <= x2;
      q03   <= pr3[SOFT_SHIFT+15:SOFT_SHIFT];
    end
  end

  // ---------------- stage 4: quotient correction, slowdown select
  logic [26:0]        qm4;
  logic [26:0]        r4;
  logic [15:0]        q4;
  logic signed [15:0] vs4_next;

  always_comb begin
    qm4 = {11'd0, q03} * {16'd0, SOFT_DIV_ODD};
    r4  = {1'b0, x3} - qm4;
    q4  = q03 + 16'(r4 >= {16'd0, SOFT_DIV_ODD});
    if (hard3) begin
      vs4_next = '0;
    end else if (slow3) begin
      vs4_next = neg3 ? -$signed(q4) : $signed(q4);   // truncates toward zero
    end else begin
      vs4_next = vc3;
    end
  end

  carry_t             c4;
  logic signed [15:0] vs4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      c4  <= c3;
      vs4 <= vs4_next;
    end
  end

  // ---------------- stage 5: displacement v * dt (Q3.28)
  logic signed [32:0] vdt5_next;

  assign vdt5_next = $signed(vs4) * $signed({1'b0, c4.dt});

  carry_t             c5;
  logic signed [15:0] vs5;
  logic signed [32:0] vdt5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      c5   <= c4;
      vs5  <= vs4;
      vdt5 <= vdt5_next;
    end
  end

  // ---------------- stage 6: next position check, elbow decisions
  logic signed [33:0] nxt6;
  logic signed [33:0] lo6;
  logic signed [33:0] hi6;
  logic               vneg6;
  logic               vpos6;
  logic               pass_lo6;
  logic               pass_hi6;
  logic               vppos6;
  logic signed [16:0] d6;

  always_comb begin
    nxt6     = $signed({{2{c5.pos[15]}}, c5.pos, 16'd0}) + $signed({vdt5[32], vdt5});
    lo6      = $signed({{2{c5.pmin[15]}}, c5.pmin, 16'd0});
    hi6      = $signed({{2{c5.pmax[15]}}, c5.pmax, 16'd0});
    vneg6    = vs5[15];
    vpos6    = !vs5[15] && (vs5 != 16'sd0);
    pass_lo6 = vneg6 && (nxt6 < lo6);
    pass_hi6 = vpos6 && (nxt6 > hi6);
    vppos6   = vpos6 && !pass_hi6;
    // distance below the guard edge at -band
    d6       = 17'sd0 - $signed({4'd0, c5.band}) - $signed({c5.pos[15], c5.pos});
  end

  logic signed [15:0] want6;
  logic signed [15:0] vp6;
  logic               block6;
  logic               push6;
  logic               scale6;
  logic [9:0]         dd6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      want6  <= c5.want;
      vp6    <= (pass_lo6 || pass_hi6) ? 16'sd0 : vs5;
      block6 <= c5.elb && vppos6 && (nxt6 > 34'sd0);
      push6  <= c5.elb && vppos6 && (d6 <= 17'sd0);
      scale6 <= c5.elb && vppos6 && (d6 > 17'sd0) && (d6 < ELBOW_SPAN);
      dd6    <= d6[9:0];
    end
  end

  // ---------------- stage 7: d squared
  logic signed [15:0] want7;
  logic signed [15:0] vp7;
  logic               block7;
  logic               push7;
  logic               scale7;
  logic [19:0]        dsq7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      want7  <= want6;
      vp7    <= vp6;
      block7 <= block6;
      push7  <= push6;
      scale7 <= scale6;
      dsq7   <= {10'd0, dd6} * {10'd0, dd6};
    end
  end

  // ---------------- stage 8: v * d^2 (v positive whenever used)
  logic signed [15:0] want8;
  logic signed [15:0] vp8;
  logic               block8;
  logic               push8;
  logic               scale8;
  logic [34:0]        p8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      want8  <= want7;
      vp8    <= vp7;
      block8 <= block7;
      push8  <= push7;
      scale8 <= scale7;
      p8     <= {20'd0, vp7[14:0]} * {15'd0, dsq7};
    end
  end

  // ---------------- stage 9: quotient estimate by reciprocal (/670761)
  logic [51:0] pr9;

  assign pr9 = {17'd0, p8} * {35'd0, ELBOW_RECIP};

  logic signed [15:0] want9;
  logic signed [15:0] vp9;
  logic               block9;
  logic               push9;
  logic               scale9;
  logic [34:0]        p9;
  logic [15:0]        q09;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      want9  <= want8;
      vp9    <= vp8;
      block9 <= block8;
      push9  <= push8;
      scale9 <= scale8;
      p9     <= p8;
      q09    <= pr9[ELBOW_SHIFT+15:ELBOW_SHIFT];
    end
  end

  // ---------------- stage 10: correction, final select, output register
  logic [34:0]        qm10;
  logic [34:0]        r10;
  logic [15:0]        q10;
  logic signed [15:0] vout_next;

  always_comb begin
    qm10 = {19'd0, q09} * {15'd0, ELBOW_DIV};
    r10  = p9 - qm10;
    q10  = q09 + 16'(r10 >= {15'd0, ELBOW_DIV});
    // block beats push beats scale
    if (block9) begin
      vout_next = '0;
    end else if (push9) begin
      vout_next = ELBOW_PUSH;
    end else if (scale9) begin
      vout_next = $signed(q10);
    end else begin
      vout_next = vp9;
    end
  end

  logic signed [15:0] vout;
  logic               limited;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      vout    <= vout_next;
      limited <= vout_next != want9;
    end
  end

  assign m_axis_tdata = {7'd0, limited, vout};

endmodule

[src/jvlp_checker.sv]
`timescale 1ns / 1ps

`include "joint_velocity_limit_projector_defines.svh"

// Port-level checks on the projector.
module jvlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // pipe is empty straight after reset
  `JVLP_ASSERT_IMP(a_reset_empty, $past(rst), !m_axis_tvalid)

  // empty output stage means no stage can be blocked
  `JVLP_ASSERT_IMP(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready)

  // stalled result holds
  `JVLP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind joint_velocity_limit_projector jvlp_checker u_jvlp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[bench/tb_joint_velocity_limit_projector.sv]
`timescale 1ns / 1ps

module tb_joint_velocity_limit_projector;
  import jvlp_pkg::*;

  // Rule constants in the block's fixed-point scales
  localparam longint SLOW_START    = 410;     // 0.1 rad
  localparam longint HARD_STOP     = 82;      // 0.02 rad
  localparam longint SLOW_SPAN_SQ  = 107584;  // (0.1 - 0.02)^2 in Q3.12 units
  localparam longint GUARD_SPAN    = 819;     // 0.2 rad
  localparam longint GUARD_SPAN_SQ = 670761;
  localparam longint GUARD_PUSH    = -2048;   // -0.5 rad/s
  localparam longint POS_SCALE     = 65536;   // Q3.12 * Q0.16 -> Q3.28

  localparam logic [CFG_IDX_W-1:0] REG_JOINT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT4 = 3'd4;

  localparam int IDLE_PERCENT  = 11;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 103;
  localparam int CALM_PHASE    = 3;   // neither side idles
  localparam int HOLD_PHASE    = 5;   // receiver holds off for a long stretch
  localparam int PAUSE_PHASE   = 6;   // sender waits for the pipeline to empty mid-phase
  localparam int HOLD_CYCLES   = 60;
  localparam int PRINT_CAP     = 100;

  // Request as packed on s_axis_tdata, joint index in the lowest bits
  typedef struct packed {
    logic [15:0]        step_time;
    logic signed [15:0] desired_velocity;
    logic signed [15:0] position;
    logic [2:0]         joint_index;
  } request_t;

  // Result as packed on m_axis_tdata[16:0]
  typedef struct packed {
    logic               was_limited;
    logic signed [15:0] safe_velocity;
  } outcome_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int          joint;
    int          pos;
    int          want;
    int          dt;
    logic        known;      // expectation typed in below
    int          safe;
    logic        limited;
    int          reg_index;
    logic [63:0] reg_value;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [55:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [23:0]          m_axis_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  // Shadow copy of the register file, updated on each config transaction
  logic [63:0] limit_regs [LIMIT_REGS];
  logic        guard_on;
  logic [12:0] guard_band;

  outcome_t predicted_velocities [$];
  int       mismatches;
  int       results_seen;
  logic     calm;
  logic     hold_request;

  // Directed part. Limits are the reset values unless a write row says otherwise
  // (pos +-12868, vel +-4096). Columns: kind, joint, pos, want, dt, known,
  // safe, limited, register, value.
  row_t directed_rows [31] = '{
    // zero request, and clamping to both velocity limits
    '{ROW_ITEM, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, 32767, 0, 1, 4096, 1, 0, 0},
    '{ROW_ITEM, 1, 0, -32768, 65535, 1, -4096, 1, 0, 0},
    '{ROW_ITEM, 1, 0, 1000, 65535, 1, 1000, 0, 0, 0},
    // joints without limits give zero
    '{ROW_ITEM, 5, 0, 100, 100, 1, 0, 1, 0, 0},
    '{ROW_ITEM, 6, 32767, -32768, 65535, 1, 0, 1, 0, 0},
    '{ROW_ITEM, 7, -32768, 0, 0, 1, 0, 0, 0, 0},
    // hard stop inside 0.02 rad, either side
    '{ROW_ITEM, 0, 12818, 2000, 0, 1, 0, 1, 0, 0},
    '{ROW_ITEM, 3, -12818, -2000, 0, 1, 0, 1, 0, 0},
    // quadratic slowdown zone
    '{ROW_ITEM, 4, 12668, 4096, 0, 0, 0, 0, 0, 0},
    // already beyond the limit
    '{ROW_ITEM, 2, 32767, 1, 0, 1, 0, 1, 0, 0},
    '{ROW_ITEM, 2, -32768, -1, 0, 1, 0, 1, 0, 0},
    // next position overshoots
    '{ROW_ITEM, 0, 12368, 4096, 65535, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 1, -12000, -3000, 32768, 0, 0, 0, 0, 0},
    // crossed velocity limits: min clamp comes last and wins
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, REG_JOINT3, 64'hFC18_03E8_4000_C000},
    '{ROW_ITEM, 3, 0, 0, 0, 1, 1000, 1, 0, 0},
    '{ROW_ITEM, 3, 0, -5000, 0, 1, 1000, 1, 0, 0},
    // elbow guard on, default band
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, REG_GUARD_ON, 64'd1},
    '{ROW_ITEM, 2, -100, 1000, 0, 1, -2048, 1, 0, 0},
    '{ROW_ITEM, 2, -100, 1000, 65535, 1, 0, 1, 0, 0},   // push, then blocked
    '{ROW_ITEM, 2, -800, 3000, 10, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 2, -1300, 2000, 0, 1, 2000, 0, 0, 0},   // below the band
    // widest band
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, REG_GUARD_BAND, 64'd8191},
    '{ROW_ITEM, 2, -9000, 500, 100, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 2, -8191, 500, 0, 1, -2048, 1, 0, 0},
    // zero band: edge sits at zero
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, REG_GUARD_BAND, 64'd0},
    '{ROW_ITEM, 2, 0, 1, 0, 1, -2048, 1, 0, 0},
    // extreme limit words
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, REG_JOINT4, 64'hFFFF_FFFF_FFFF_FFFF},
    '{ROW_ITEM, 4, 0, 5, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, REG_JOINT4, 64'd0},
    '{ROW_ITEM, 4, 0, -5, 0, 1, 0, 1, 0, 0}
  };

  joint_velocity_limit_projector uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ends a hung run
  initial begin
    #3_000_000;
    $display("tb_joint_velocity_limit_projector: done, errors");
    $finish;
  end

  // Expected safe velocity for one request, from the shadow registers.
  // Everything is widened to 64 bits so the next-position test is exact.
  function automatic outcome_t project_velocity(input request_t req);
    limits_t  lim;
    longint   pos, want, dt, v, v_in;
    longint   pmin, pmax, vmin, vmax;
    longint   gap, e, guard_edge, d, drift;
    outcome_t res;
    pos  = req.position;
    want = req.desired_velocity;
    dt   = req.step_time;
    v    = 0;
    if (req.joint_index < JOINT_COUNT && req.joint_index < LIMIT_REGS) begin
      lim  = limits_t'(limit_regs[req.joint_index]);
      pmin = lim.pmin;
      pmax = lim.pmax;
      vmin = lim.vmin;
      vmax = lim.vmax;
      v = want;
      if (v > vmax) v = vmax;
      if (v < vmin) v = vmin;
      // slow down towards whichever position limit we are heading for
      if (v != 0) begin
        gap = (v > 0) ? pmax - pos : pos - pmin;
        if (gap < HARD_STOP) begin
          v = 0;
        end else if (gap < SLOW_START) begin
          e = gap - HARD_STOP;
          v = (v * e * e) / SLOW_SPAN_SQ;
        end
      end
      drift = pos * POS_SCALE + v * dt;
      if (v < 0 && drift < pmin * POS_SCALE) v = 0;
      if (v > 0 && drift > pmax * POS_SCALE) v = 0;
      // elbow rule works from the velocity as it stood after the limit checks
      if (req.joint_index == ELBOW_JOINT && guard_on) begin
        v_in       = v;
        guard_edge = -longint'(guard_band);
        drift      = pos * POS_SCALE + v_in * dt;
        if (v_in > 0 && pos > guard_edge - GUARD_SPAN) begin
          d = guard_edge - pos;
          if (d <= 0) begin
            v = GUARD_PUSH;
          end else if (d < GUARD_SPAN) begin
            v = (v * d * d) / GUARD_SPAN_SQ;
          end
        end
        if (v_in > 0 && drift > 0) v = 0;
      end
    end
    res.safe_velocity = v[15:0];
    res.was_limited   = (v != want);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // One config transaction; cfg_valid is left high so back-to-back writes
  // need no second assignment in a step. The caller lowers it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx < LIMIT_REGS) limit_regs[idx] = value;
    else if (idx == REG_GUARD_ON) guard_on = value[0];
    else if (idx == REG_GUARD_BAND) guard_band = value[12:0];
    @(negedge clk);
  endtask

  // Input transaction with random gaps ahead of it. The expectation is taken
  // at acceptance, so it sees exactly the registers the block sees.
  task automatic send_request(input request_t req, input logic typed,
                              input outcome_t typed_outcome);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  <= 56'(req);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predicted_velocities.push_back(typed ? typed_outcome : project_velocity(req));
    @(negedge clk);
  endtask

  // Sender goes quiet until every expected result is back. Every request
  // yields a result, so an empty queue means an empty pipeline.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (predicted_velocities.size() != 0);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        held = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (held > 0) begin
        m_axis_tready <= 1'b0;
        held--;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Output checker: in-order, field by field
  always @(posedge clk) begin
    outcome_t got;
    outcome_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = outcome_t'(m_axis_tdata[16:0]);
      results_seen++;
      if (predicted_velocities.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected, tdata 0x%06h",
                                  results_seen, m_axis_tdata));
      end else begin
        due = predicted_velocities.pop_front();
        if (got.safe_velocity !== due.safe_velocity)
          report_mismatch($sformatf("result %0d safe_velocity %0d, expected %0d",
                                    results_seen, got.safe_velocity, due.safe_velocity));
        if (got.was_limited !== due.was_limited)
          report_mismatch($sformatf("result %0d was_limited %0b, expected %0b",
                                    results_seen, got.was_limited, due.was_limited));
      end
    end
  end

  initial begin : stimulus
    int          phase, n, j, pos_i, vel_i, band, mode;
    logic [63:0] word;
    limits_t     lim;
    request_t    req;
    outcome_t    typed;

    // every input known from time zero
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    calm          = 1'b0;
    hold_request  = 1'b0;
    mismatches    = 0;
    results_seen  = 0;
    foreach (limit_regs[k]) limit_regs[k] = LIMITS_RESET;
    guard_on   = 1'b0;
    guard_band = GUARD_BAND_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed table ---
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_drained();
        write_register(3'(directed_rows[r].reg_index), directed_rows[r].reg_value);
        cfg_valid <= 1'b0;
        @(negedge clk);
      end else begin
        req.joint_index      = 3'(directed_rows[r].joint);
        req.position         = 16'(directed_rows[r].pos);
        req.desired_velocity = 16'(directed_rows[r].want);
        req.step_time        = 16'(directed_rows[r].dt);
        typed.safe_velocity  = 16'(directed_rows[r].safe);
        typed.was_limited    = directed_rows[r].limited;
        send_request(req, directed_rows[r].known, typed);
      end
    end

    // --- random phases, each with fresh register settings ---
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      calm = (phase == CALM_PHASE);

      for (j = 0; j < LIMIT_REGS; j++) begin
        if ($urandom_range(7) == 0) begin
          word = {$urandom, $urandom};  // anything, crossed limits included
        end else begin
          lim.pmax = 16'($urandom_range(20000, 100));
          lim.pmin = 16'(-int'($urandom_range(20000, 100)));
          lim.vmax = 16'($urandom_range(8192, 1));
          lim.vmin = 16'(-int'($urandom_range(8192, 1)));
          word = lim;
        end
        write_register(REG_JOINT0 + 3'(j), word);
      end
      write_register(REG_GUARD_ON, 64'(phase % 2 == 0));
      case (phase)
        1:       band = 0;
        4:       band = 8191;
        default: band = $urandom_range(1500);
      endcase
      write_register(REG_GUARD_BAND, 64'(band));
      cfg_valid <= 1'b0;
      @(negedge clk);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == HOLD_PHASE && n == 10) hold_request = 1'b1;
        if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2) wait_drained();

        if ($urandom_range(9) == 0) req.joint_index = 3'($urandom_range(7, 5));
        else req.joint_index = 3'($urandom_range(4));
        lim  = (req.joint_index < LIMIT_REGS) ? limits_t'(limit_regs[req.joint_index])
                                              : limits_t'(LIMITS_RESET);
        mode = $urandom_range(5);
        // mostly aim at the interesting zones: near a limit or the elbow band
        case (mode)
          0, 1: begin
            pos_i = int'(lim.pmax) - int'($urandom_range(600)) + 40;
            vel_i = int'($urandom_range(7000)) - 1500;
          end
          2: begin
            pos_i = int'(lim.pmin) + int'($urandom_range(600)) - 40;
            vel_i = 1500 - int'($urandom_range(7000));
          end
          3: begin
            if (guard_on) req.joint_index = ELBOW_JOINT;
            pos_i = -int'(guard_band) - int'($urandom_range(950)) + 60;
            vel_i = int'($urandom_range(7000)) - 1500;
          end
          4: begin
            pos_i = int'($urandom_range(400)) - 200;
            vel_i = int'($urandom_range(10000)) - 5000;
          end
          default: begin
            pos_i = $urandom;
            vel_i = $urandom;
          end
        endcase
        if ($urandom_range(3) == 0) vel_i = $urandom;
        req.position         = 16'(pos_i);
        req.desired_velocity = 16'(vel_i);
        req.step_time        = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3000));
        send_request(req, 1'b0, '0);
      end
    end

    // --- wind down ---
    wait_drained();
    calm = 1'b0;
    repeat (4 * PIPE_DEPTH) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_joint_velocity_limit_projector: done, clean");
    end else begin
      $display("tb_joint_velocity_limit_projector: done, errors");
    end
    $finish;
  end

endmodule
